[hdl/cfr_pkg.sv]
// ----------------------------------------------------------------------------
// cfr_pkg: shared types and constants of the checksummed frame receiver
// Holds the configuration bundle, the frame record passed from the parser
// to the decoder, register indexes and frame code constants.
// ----------------------------------------------------------------------------
package cfr_pkg;

	// Frame geometry
	localparam int PAYLOAD_BYTES = 8;
	localparam int PAYLOAD_W     = 64;
	localparam int ALIGN_SHIFT   = ((8 - PAYLOAD_BYTES) % 8) * 8;
	localparam int FIFO_DEPTH    = 2;

	// Configuration register indexes
	localparam logic [2:0] REG_FIRST_SYNC  = 3'd0;
	localparam logic [2:0] REG_SECOND_SYNC = 3'd1;
	localparam logic [2:0] REG_SENDER_ID   = 3'd2;
	localparam logic [2:0] REG_FIRST_TAIL  = 3'd3;
	localparam logic [2:0] REG_SECOND_TAIL = 3'd4;

	// Register reset values
	localparam logic [7:0] RST_FIRST_SYNC  = 8'd170;
	localparam logic [7:0] RST_SECOND_SYNC = 8'd187;
	localparam logic [7:0] RST_SENDER_ID   = 8'd0;
	localparam logic [7:0] RST_FIRST_TAIL  = 8'd238;
	localparam logic [7:0] RST_SECOND_TAIL = 8'd255;

	// Frame codes
	localparam logic [7:0] FC_INFO       = 8'h01;
	localparam logic [7:0] SFC_RUN_INFO  = 8'h00;
	localparam logic [7:0] SFC_FAULT     = 8'h01;

	localparam logic [1:0] KIND_RUN_INFO = 2'd0;
	localparam logic [1:0] KIND_FAULT    = 2'd1;
	localparam logic [1:0] KIND_OTHER    = 2'd2;

	localparam logic [3:0] FAULT_NONE    = 4'd0;
	localparam logic [3:0] FAULT_LV2_B0  = 4'd14;
	localparam logic [3:0] FAULT_LV2_B1  = 4'd15;
	localparam int         LV1_BITS      = 13;

	typedef struct packed {
		logic [7:0] first_sync;
		logic [7:0] second_sync;
		logic [7:0] sender_id;
		logic [7:0] first_tail;
		logic [7:0] second_tail;
	} cfg_t;

	typedef struct packed {
		logic [7:0]           function_code;
		logic [7:0]           subfunction_code;
		logic [PAYLOAD_W-1:0] payload;
	} frame_t;

endpackage

[hdl/cfr_front.sv]
// ----------------------------------------------------------------------------
// cfr_front: frame parser
// Hunts for sync bytes, checks id, checksum and tail, and pushes each good
// frame as one record into the frame queue.
// ----------------------------------------------------------------------------
module cfr_front import cfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       fifo_full,
	output logic       push,
	output frame_t     push_frame
);

	typedef enum logic [3:0] {
		PH_SYNC1   = 4'd0,
		PH_SYNC2   = 4'd1,
		PH_ID      = 4'd2,
		PH_FC      = 4'd3,
		PH_SFC     = 4'd4,
		PH_PAYLOAD = 4'd5,
		PH_SUM_HI  = 4'd6,
		PH_SUM_LO  = 4'd7,
		PH_TAIL1   = 4'd8,
		PH_TAIL2   = 4'd9
	} phase_t;

	phase_t               phase_q;
	logic [3:0]           count_q;
	logic [3:0]           count_next;
	logic [7:0]           fc_q;
	logic [7:0]           sfc_q;
	logic [PAYLOAD_W-1:0] payload_q;
	logic [15:0]          sum_q;
	logic [7:0]           sum_hi_q;
	logic                 accept;

	assign in_ready   = !fifo_full;
	assign accept     = in_valid && in_ready;
	assign count_next = count_q + 4'd1;

	// Push a record when the second tail byte matches
	assign push = accept && (phase_q == PH_TAIL2) && (rx_byte == cfg.second_tail);
	assign push_frame.function_code    = fc_q;
	assign push_frame.subfunction_code = sfc_q;
	assign push_frame.payload          = payload_q << ALIGN_SHIFT;

	// Advance the parse phase on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC1;
			count_q <= 4'd0;
		end else if (accept) begin
			case (phase_q)
				PH_SYNC1: begin
					if (rx_byte == cfg.first_sync) phase_q <= PH_SYNC2;
				end
				PH_SYNC2: begin
					phase_q <= (rx_byte == cfg.second_sync) ? PH_ID : PH_SYNC1;
				end
				PH_ID: begin
					phase_q <= (rx_byte == cfg.sender_id) ? PH_FC : PH_SYNC1;
				end
				PH_FC: begin
					phase_q <= PH_SFC;
				end
				PH_SFC: begin
					count_q <= 4'd0;
					phase_q <= PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					count_q <= count_next;
					if (count_next >= 4'(PAYLOAD_BYTES)) phase_q <= PH_SUM_HI;
				end
				PH_SUM_HI: begin
					phase_q <= PH_SUM_LO;
				end
				PH_SUM_LO: begin
					phase_q <= ({sum_hi_q, rx_byte} == sum_q) ? PH_TAIL1 : PH_SYNC1;
				end
				PH_TAIL1: begin
					phase_q <= (rx_byte == cfg.first_tail) ? PH_TAIL2 : PH_SYNC1;
				end
				PH_TAIL2: begin
					phase_q <= PH_SYNC1;
				end
				default: begin
					phase_q <= PH_SYNC1;
				end
			endcase
		end
	end

	// Capture codes, payload and checksum terms
	always_ff @(posedge clk) begin
		if (accept) begin
			case (phase_q)
				PH_ID: begin
					sum_q <= {8'd0, rx_byte};
				end
				PH_FC: begin
					fc_q  <= rx_byte;
					sum_q <= sum_q + {8'd0, rx_byte};
				end
				PH_SFC: begin
					sfc_q     <= rx_byte;
					sum_q     <= sum_q + {8'd0, rx_byte};
					payload_q <= '0;
				end
				PH_PAYLOAD: begin
					payload_q <= {payload_q[PAYLOAD_W-9:0], rx_byte};
					sum_q     <= sum_q + {8'd0, rx_byte};
				end
				PH_SUM_HI: begin
					sum_hi_q <= rx_byte;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[hdl/cfr_fifo.sv]
// ----------------------------------------------------------------------------
// cfr_fifo: frame record queue
// Two-entry queue that lets the parser and the decoder stall independently.
// ----------------------------------------------------------------------------
module cfr_fifo import cfr_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  frame_t push_frame,
	output logic   full,
	output logic   not_empty,
	input  logic   pop,
	output frame_t pop_frame
);

	frame_t     mem_q [FIFO_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign full      = (count_q == 2'(FIFO_DEPTH));
	assign not_empty = (count_q != 2'd0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_frame = mem_q[rd_ptr_q];

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop)  rd_ptr_q <= !rd_ptr_q;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Store pushed records
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_frame;
	end

endmodule

[hdl/cfr_back.sv]
// ----------------------------------------------------------------------------
// cfr_back: frame decoder and output register
// Pops a frame record, decodes run-info and fault views, and holds the
// result until the receiver takes it.
// ----------------------------------------------------------------------------
module cfr_back import cfr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fifo_not_empty,
	input  frame_t               fifo_frame,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           function_code,
	output logic [7:0]           subfunction_code,
	output logic [PAYLOAD_W-1:0] payload,
	output logic [1:0]           frame_kind,
	output logic [15:0]          feedback_speed,
	output logic [7:0]           lower_status,
	output logic [3:0]           fault_code
);

	logic                 valid_q;
	logic [7:0]           fc_q;
	logic [7:0]           sfc_q;
	logic [PAYLOAD_W-1:0] payload_q;
	logic [1:0]           kind_q;
	logic [15:0]          speed_q;
	logic [7:0]           status_q;
	logic [3:0]           fault_q;

	logic [15:0] lv1;
	logic [7:0]  lv2;
	logic [3:0]  fault_dec;
	logic        is_info;
	logic        is_run;
	logic        is_fault;

	assign pop     = fifo_not_empty && (!valid_q || out_ready);
	assign lv1     = fifo_frame.payload[63:48];
	assign lv2     = fifo_frame.payload[39:32];
	assign is_info = (fifo_frame.function_code == FC_INFO);
	assign is_run  = is_info && (fifo_frame.subfunction_code == SFC_RUN_INFO);
	assign is_fault = is_info && (fifo_frame.subfunction_code == SFC_FAULT);

	// Priority-encode the lowest level-one bit, then the level-two bits
	always_comb begin
		if (lv2[0])      fault_dec = FAULT_LV2_B0;
		else if (lv2[1]) fault_dec = FAULT_LV2_B1;
		else             fault_dec = FAULT_NONE;
		for (int i = LV1_BITS - 1; i >= 0; i--) begin
			if (lv1[i]) fault_dec = 4'(i + 1);
		end
	end

	// Hold the output valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Load the decoded result
	always_ff @(posedge clk) begin
		if (pop) begin
			fc_q      <= fifo_frame.function_code;
			sfc_q     <= fifo_frame.subfunction_code;
			payload_q <= fifo_frame.payload;
			kind_q    <= is_run ? KIND_RUN_INFO : (is_fault ? KIND_FAULT : KIND_OTHER);
			speed_q   <= is_run ? lv1 : 16'd0;
			status_q  <= is_run ? fifo_frame.payload[47:40] : 8'd0;
			fault_q   <= is_fault ? fault_dec : FAULT_NONE;
		end
	end

	assign out_valid        = valid_q;
	assign function_code    = fc_q;
	assign subfunction_code = sfc_q;
	assign payload          = payload_q;
	assign frame_kind       = kind_q;
	assign feedback_speed   = speed_q;
	assign lower_status     = status_q;
	assign fault_code       = fault_q;

endmodule

[hdl/checksummed_frame_receiver_top.sv]
// ----------------------------------------------------------------------------
// checksummed_frame_receiver_top: checksummed frame receiver
// Parses a byte stream into checksummed frames and emits decoded frames.
//
// Usage:
//   Input channel in_valid/in_ready/rx_byte carries one received byte per
//   request; the parser takes one byte every cycle while its frame queue
//   has room. A frame is 17 bytes; a good frame yields one output request
//   on out_valid/out_ready with codes, payload and decoded fields.
//   The edge that accepts the last tail byte writes the frame queue; the output
//   register then loads from the queue once it is empty or being taken.
//   Throughput: one byte per cycle, set by the single-step parse phase
//   register; the two-entry frame queue and the output register absorb
//   receiver stalls. If the receiver stalls long enough that the queue
//   fills, in_ready drops until a frame is taken.
//   Reset (arst_n low) returns the parser to hunting the first sync byte,
//   empties the queue and restores register defaults.
//   Registers at byte addresses 0,4,8,12,16 over the APB port: first sync,
//   second sync, sender id, first tail, second tail.
// ----------------------------------------------------------------------------
module checksummed_frame_receiver_top import cfr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [4:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           rx_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           function_code,
	output logic [7:0]           subfunction_code,
	output logic [PAYLOAD_W-1:0] payload,
	output logic [1:0]           frame_kind,
	output logic [15:0]          feedback_speed,
	output logic [7:0]           lower_status,
	output logic [3:0]           fault_code
);

	cfg_t       cfg_q;
	logic [2:0] reg_idx;
	logic       cfg_wr;
	logic       push;
	frame_t     push_frame;
	logic       fifo_full;
	logic       fifo_not_empty;
	logic       pop;
	frame_t     pop_frame;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_sync  <= RST_FIRST_SYNC;
			cfg_q.second_sync <= RST_SECOND_SYNC;
			cfg_q.sender_id   <= RST_SENDER_ID;
			cfg_q.first_tail  <= RST_FIRST_TAIL;
			cfg_q.second_tail <= RST_SECOND_TAIL;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_FIRST_SYNC:  cfg_q.first_sync  <= pwdata[7:0];
				REG_SECOND_SYNC: cfg_q.second_sync <= pwdata[7:0];
				REG_SENDER_ID:   cfg_q.sender_id   <= pwdata[7:0];
				REG_FIRST_TAIL:  cfg_q.first_tail  <= pwdata[7:0];
				REG_SECOND_TAIL: cfg_q.second_tail <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// Read back configuration registers
	always_comb begin
		case (reg_idx)
			REG_FIRST_SYNC:  prdata = {24'd0, cfg_q.first_sync};
			REG_SECOND_SYNC: prdata = {24'd0, cfg_q.second_sync};
			REG_SENDER_ID:   prdata = {24'd0, cfg_q.sender_id};
			REG_FIRST_TAIL:  prdata = {24'd0, cfg_q.first_tail};
			REG_SECOND_TAIL: prdata = {24'd0, cfg_q.second_tail};
			default:         prdata = 32'd0;
		endcase
	end

	cfr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.fifo_full  (fifo_full),
		.push       (push),
		.push_frame (push_frame)
	);

	cfr_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_frame (push_frame),
		.full       (fifo_full),
		.not_empty  (fifo_not_empty),
		.pop        (pop),
		.pop_frame  (pop_frame)
	);

	cfr_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.fifo_not_empty   (fifo_not_empty),
		.fifo_frame       (pop_frame),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.function_code    (function_code),
		.subfunction_code (subfunction_code),
		.payload          (payload),
		.frame_kind       (frame_kind),
		.feedback_speed   (feedback_speed),
		.lower_status     (lower_status),
		.fault_code       (fault_code)
	);

endmodule

[dv/cfr_frame_checker.sv]
// ----------------------------------------------------------------------------
// cfr_frame_checker: result checker for the checksummed frame receiver
// Watches the byte, result and register ports, runs its own frame parser
// on every accepted byte and compares each result request against the
// oldest frame that the parser expects. Hands its failure count and the
// number of frames still due to the testbench top.
// ----------------------------------------------------------------------------
module cfr_frame_checker import cfr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic                 pready,
	input  logic [4:0]           paddr,
	input  logic [31:0]          pwdata,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [7:0]           rx_byte,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [7:0]           function_code,
	input  logic [7:0]           subfunction_code,
	input  logic [PAYLOAD_W-1:0] payload,
	input  logic [1:0]           frame_kind,
	input  logic [15:0]          feedback_speed,
	input  logic [7:0]           lower_status,
	input  logic [3:0]           fault_code,
	output int                   fail_count,
	output int                   frames_pending
);

	typedef enum logic [3:0] {
		HUNT_SYNC1,
		WAIT_SYNC2,
		WAIT_SENDER,
		WAIT_FUNC,
		WAIT_SUBFUNC,
		TAKE_PAYLOAD,
		TAKE_SUM_HI,
		TAKE_SUM_LO,
		WAIT_TAIL1,
		WAIT_TAIL2
	} parse_phase_t;

	typedef struct packed {
		logic [7:0]           function_code;
		logic [7:0]           subfunction_code;
		logic [PAYLOAD_W-1:0] payload;
		logic [1:0]           frame_kind;
		logic [15:0]          feedback_speed;
		logic [7:0]           lower_status;
		logic [3:0]           fault_code;
	} decoded_frame_t;

	decoded_frame_t       frames_due[$];
	cfg_t                 regs;
	parse_phase_t         phase;
	logic [3:0]           bytes_taken;
	logic [7:0]           func_held;
	logic [7:0]           subfunc_held;
	logic [7:0]           sum_hi_held;
	logic [PAYLOAD_W-1:0] payload_acc;
	logic [15:0]          sum_acc;

	// Lowest level-one bit wins, then level-two bit 0, then bit 1
	function automatic logic [3:0] fault_of(input logic [PAYLOAD_W-1:0] aligned);
		logic [15:0] level_one;
		logic [7:0]  level_two;
		logic [3:0]  code;
		int          i;
		level_one = aligned[PAYLOAD_W-1 -: 16];
		level_two = aligned[PAYLOAD_W-25 -: 8];
		code = FAULT_NONE;
		if (level_two[1])
			code = FAULT_LV2_B1;
		if (level_two[0])
			code = FAULT_LV2_B0;
		for (i = LV1_BITS - 1; i >= 0; i--) begin
			if (level_one[i])
				code = 4'(i + 1);
		end
		return code;
	endfunction

	// Build the decoded view of a frame that passed every test
	function automatic decoded_frame_t decode_frame(input logic [7:0] fc, input logic [7:0] sfc,
			input logic [PAYLOAD_W-1:0] acc);
		decoded_frame_t       r;
		logic [PAYLOAD_W-1:0] aligned;
		aligned = acc << ALIGN_SHIFT;
		r.function_code    = fc;
		r.subfunction_code = sfc;
		r.payload          = aligned;
		r.feedback_speed   = '0;
		r.lower_status     = '0;
		r.fault_code       = FAULT_NONE;
		if (fc == FC_INFO && sfc == SFC_RUN_INFO) begin
			r.frame_kind     = KIND_RUN_INFO;
			r.feedback_speed = aligned[PAYLOAD_W-1 -: 16];
			r.lower_status   = aligned[PAYLOAD_W-17 -: 8];
		end else if (fc == FC_INFO && sfc == SFC_FAULT) begin
			r.frame_kind = KIND_FAULT;
			r.fault_code = fault_of(aligned);
		end else begin
			r.frame_kind = KIND_OTHER;
		end
		return r;
	endfunction

	// Advance the frame parser by one byte; a mismatch drops the byte
	task automatic parse_byte(input logic [7:0] b);
		logic [15:0] got_sum;
		case (phase)
			HUNT_SYNC1: begin
				if (b == regs.first_sync)
					phase = WAIT_SYNC2;
			end
			WAIT_SYNC2: begin
				phase = (b == regs.second_sync) ? WAIT_SENDER : HUNT_SYNC1;
			end
			WAIT_SENDER: begin
				if (b == regs.sender_id) begin
					sum_acc = {8'h00, b};
					phase = WAIT_FUNC;
				end else begin
					phase = HUNT_SYNC1;
				end
			end
			WAIT_FUNC: begin
				func_held = b;
				sum_acc = sum_acc + {8'h00, b};
				phase = WAIT_SUBFUNC;
			end
			WAIT_SUBFUNC: begin
				subfunc_held = b;
				sum_acc = sum_acc + {8'h00, b};
				bytes_taken = '0;
				payload_acc = '0;
				phase = TAKE_PAYLOAD;
			end
			TAKE_PAYLOAD: begin
				payload_acc = {payload_acc[PAYLOAD_W-9:0], b};
				sum_acc = sum_acc + {8'h00, b};
				bytes_taken = bytes_taken + 4'd1;
				if (bytes_taken >= PAYLOAD_BYTES)
					phase = TAKE_SUM_HI;
			end
			TAKE_SUM_HI: begin
				sum_hi_held = b;
				phase = TAKE_SUM_LO;
			end
			TAKE_SUM_LO: begin
				got_sum = {sum_hi_held, b};
				phase = (got_sum == sum_acc) ? WAIT_TAIL1 : HUNT_SYNC1;
			end
			WAIT_TAIL1: begin
				phase = (b == regs.first_tail) ? WAIT_TAIL2 : HUNT_SYNC1;
			end
			WAIT_TAIL2: begin
				phase = HUNT_SYNC1;
				if (b == regs.second_tail)
					frames_due.push_back(decode_frame(func_held, subfunc_held, payload_acc));
			end
			default: begin
				phase = HUNT_SYNC1;
			end
		endcase
	endtask

	task automatic check_field(input string field, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		decoded_frame_t want;
		if (!arst_n) begin
			regs = '{first_sync: RST_FIRST_SYNC, second_sync: RST_SECOND_SYNC,
				sender_id: RST_SENDER_ID, first_tail: RST_FIRST_TAIL,
				second_tail: RST_SECOND_TAIL};
			phase = HUNT_SYNC1;
			bytes_taken = '0;
			func_held = '0;
			subfunc_held = '0;
			sum_hi_held = '0;
			payload_acc = '0;
			sum_acc = '0;
			frames_due.delete();
			fail_count = 0;
			frames_pending <= 0;
		end else begin
			// compare a result request with the oldest frame due
			if (out_valid && out_ready) begin
				if (frames_due.size() == 0) begin
					$error("result request with no frame due: function_code 0x%0h",
						function_code);
					fail_count++;
				end else begin
					want = frames_due.pop_front();
					check_field("function_code", 64'(want.function_code),
						64'(function_code));
					check_field("subfunction_code", 64'(want.subfunction_code),
						64'(subfunction_code));
					check_field("payload", want.payload, payload);
					check_field("frame_kind", 64'(want.frame_kind), 64'(frame_kind));
					check_field("feedback_speed", 64'(want.feedback_speed),
						64'(feedback_speed));
					check_field("lower_status", 64'(want.lower_status), 64'(lower_status));
					check_field("fault_code", 64'(want.fault_code), 64'(fault_code));
				end
			end

			// mirror register writes; indexes past the file are ignored
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_FIRST_SYNC:  regs.first_sync  = pwdata[7:0];
					REG_SECOND_SYNC: regs.second_sync = pwdata[7:0];
					REG_SENDER_ID:   regs.sender_id   = pwdata[7:0];
					REG_FIRST_TAIL:  regs.first_tail  = pwdata[7:0];
					REG_SECOND_TAIL: regs.second_tail = pwdata[7:0];
					default: ;
				endcase
			end

			if (in_valid && in_ready)
				parse_byte(rx_byte);

			frames_pending <= frames_due.size();
		end
	end

endmodule

[dv/tb_checksummed_frame_receiver_top.sv]
// ----------------------------------------------------------------------------
// tb_checksummed_frame_receiver_top: testbench of the frame receiver
// Sends directed frames (run info, fault codes, other codes, each kind of
// broken frame) and then random frame streams mixed with corrupt frames and
// noise under several register settings, with random sender gaps and
// receiver stalls. A checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_checksummed_frame_receiver_top;
	import cfr_pkg::*;

	// Byte positions within one frame
	localparam int POS_SYNC2    = 1;
	localparam int POS_SENDER   = 2;
	localparam int POS_FUNC     = 3;
	localparam int POS_SUBFUNC  = 4;
	localparam int POS_PAYLOAD  = 5;
	localparam int POS_SUM_HI   = POS_PAYLOAD + PAYLOAD_BYTES;
	localparam int POS_SUM_LO   = POS_SUM_HI + 1;
	localparam int POS_TAIL1    = POS_SUM_HI + 2;
	localparam int POS_TAIL2    = POS_SUM_HI + 3;
	localparam int FRAME_BYTES  = POS_SUM_HI + 4;
	localparam int NO_FLAW      = -1;

	localparam logic [2:0] REG_BEYOND = 3'd5;
	localparam int SEGMENT_BYTES      = 400;
	localparam int SEGMENTS           = 4;
	localparam int DRAIN_CYCLES       = 4;
	localparam int QUIET_LIMIT        = 1000;

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [4:0]           paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;
	logic                 in_valid;
	logic                 in_ready;
	logic [7:0]           rx_byte;
	logic                 out_valid;
	logic                 out_ready;
	logic [7:0]           function_code;
	logic [7:0]           subfunction_code;
	logic [PAYLOAD_W-1:0] payload;
	logic [1:0]           frame_kind;
	logic [15:0]          feedback_speed;
	logic [7:0]           lower_status;
	logic [3:0]           fault_code;

	int   fail_count;
	int   frames_pending;
	int   bytes_sent;
	int   quiet_cycles = 0;
	logic sender_idles = 1'b1;
	logic receiver_stalls = 1'b1;
	cfg_t link_cfg;

	checksummed_frame_receiver_top dut (.*);

	cfr_frame_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Hold off result requests in random bursts
	initial begin
		out_ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (receiver_stalls && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	// Offer one byte request, with an optional idle burst first
	task automatic send_byte(input logic [7:0] b);
		if (sender_idles && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	// Build a frame under the current settings, optionally damage one byte
	// and cut it short, then send it
	task automatic send_frame(input logic [7:0] fc, input logic [7:0] sfc,
			input logic [PAYLOAD_W-1:0] pl, input int flaw, input int len);
		logic [7:0]  fb [FRAME_BYTES];
		logic [15:0] sum;
		int          i;
		fb[0]           = link_cfg.first_sync;
		fb[POS_SYNC2]   = link_cfg.second_sync;
		fb[POS_SENDER]  = link_cfg.sender_id;
		fb[POS_FUNC]    = fc;
		fb[POS_SUBFUNC] = sfc;
		for (i = 0; i < PAYLOAD_BYTES; i++)
			fb[POS_PAYLOAD + i] = pl[PAYLOAD_W - 1 - 8 * i -: 8];
		sum = '0;
		for (i = POS_SENDER; i < POS_SUM_HI; i++)
			sum = sum + {8'h00, fb[i]};
		fb[POS_SUM_HI] = sum[15:8];
		fb[POS_SUM_LO] = sum[7:0];
		fb[POS_TAIL1]  = link_cfg.first_tail;
		fb[POS_TAIL2]  = link_cfg.second_tail;
		if (flaw != NO_FLAW)
			fb[flaw] = fb[flaw] ^ 8'($urandom_range(1, 255));
		for (i = 0; i < len; i++)
			send_byte(fb[i]);
	endtask

	// Noise leans on header and trailer values to provoke false starts
	function automatic logic [7:0] noise_byte();
		case ($urandom_range(0, 4))
			0: return link_cfg.first_sync;
			1: return link_cfg.second_sync;
			2: return link_cfg.first_tail;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Pick frame codes and a payload that reach every decoded view
	task automatic random_frame(output logic [7:0] fc, output logic [7:0] sfc,
			output logic [PAYLOAD_W-1:0] pl);
		pl = {$urandom(), $urandom()};
		case ($urandom_range(0, 3))
			0: begin
				fc = FC_INFO;
				sfc = SFC_RUN_INFO;
			end
			1: begin
				fc = FC_INFO;
				sfc = SFC_FAULT;
			end
			2: begin
				fc = FC_INFO;
				sfc = 8'($urandom_range(0, 255));
			end
			default: begin
				fc = 8'($urandom_range(0, 255));
				sfc = 8'($urandom_range(0, 255));
			end
		endcase
		case ($urandom_range(0, 3))
			0: pl[PAYLOAD_W-1 -: 16] = 16'h0001 << $urandom_range(0, 15);
			1: pl[PAYLOAD_W-1 -: 16] = 16'($urandom()) & 16'hE000;
			default: ;
		endcase
	endtask

	// Drop valid and wait until every expected frame has come out
	task automatic drain_frames();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (frames_pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'h000000, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic reconfigure(input cfg_t c);
		drain_frames();
		write_reg(REG_FIRST_SYNC, c.first_sync);
		write_reg(REG_SECOND_SYNC, c.second_sync);
		write_reg(REG_SENDER_ID, c.sender_id);
		write_reg(REG_FIRST_TAIL, c.first_tail);
		write_reg(REG_SECOND_TAIL, c.second_tail);
		link_cfg = c;
	endtask

	initial begin
		cfg_t                 c;
		logic [7:0]           fc;
		logic [7:0]           sfc;
		logic [PAYLOAD_W-1:0] pl;
		int                   seg;
		int                   pick;

		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		rx_byte <= '0;
		link_cfg = '{first_sync: RST_FIRST_SYNC, second_sync: RST_SECOND_SYNC,
			sender_id: RST_SENDER_ID, first_tail: RST_FIRST_TAIL,
			second_tail: RST_SECOND_TAIL};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// run info at the payload extremes
		send_frame(FC_INFO, SFC_RUN_INFO, '0, NO_FLAW, FRAME_BYTES);
		send_frame(FC_INFO, SFC_RUN_INFO, '1, NO_FLAW, FRAME_BYTES);
		// fault frames: lowest and highest level-one bits, level-two bits, none
		send_frame(FC_INFO, SFC_FAULT, '1, NO_FLAW, FRAME_BYTES);
		send_frame(FC_INFO, SFC_FAULT, 64'h0A30_0003_0000_0000, NO_FLAW, FRAME_BYTES);
		send_frame(FC_INFO, SFC_FAULT, 64'h1000_0000_0000_0000, NO_FLAW, FRAME_BYTES);
		send_frame(FC_INFO, SFC_FAULT, 64'hE000_0001_0000_0000, NO_FLAW, FRAME_BYTES);
		send_frame(FC_INFO, SFC_FAULT, 64'h0000_0002_0000_0000, NO_FLAW, FRAME_BYTES);
		send_frame(FC_INFO, SFC_FAULT, 64'hE000_FFFC_FFFF_FFFF, NO_FLAW, FRAME_BYTES);
		// frames of other kinds
		send_frame(FC_INFO, 8'h02, {$urandom(), $urandom()}, NO_FLAW, FRAME_BYTES);
		send_frame(8'h00, SFC_FAULT, '1, NO_FLAW, FRAME_BYTES);
		send_frame(8'hFF, 8'hFF, '1, NO_FLAW, FRAME_BYTES);
		// each kind of broken frame, then a clean one
		send_frame(FC_INFO, SFC_RUN_INFO, '1, 0, FRAME_BYTES);
		send_frame(FC_INFO, SFC_RUN_INFO, '1, POS_SYNC2, FRAME_BYTES);
		send_frame(FC_INFO, SFC_RUN_INFO, '1, POS_SENDER, FRAME_BYTES);
		send_frame(FC_INFO, SFC_RUN_INFO, '1, POS_PAYLOAD, FRAME_BYTES);
		send_frame(FC_INFO, SFC_RUN_INFO, '1, POS_SUM_HI, FRAME_BYTES);
		send_frame(FC_INFO, SFC_RUN_INFO, '1, POS_SUM_LO, FRAME_BYTES);
		send_frame(FC_INFO, SFC_RUN_INFO, '1, POS_TAIL1, FRAME_BYTES);
		send_frame(FC_INFO, SFC_RUN_INFO, '1, POS_TAIL2, FRAME_BYTES);
		send_frame(FC_INFO, SFC_FAULT, '0, NO_FLAW, FRAME_BYTES);
		// a repeated first sync byte is dropped, so the frame behind it is lost
		send_byte(link_cfg.first_sync);
		send_frame(FC_INFO, SFC_RUN_INFO, '0, NO_FLAW, FRAME_BYTES);
		// cut-off frame, then recovery
		send_frame(FC_INFO, SFC_FAULT, '1, NO_FLAW, POS_SUM_HI);
		send_frame(8'h5A, 8'hA5, {$urandom(), $urandom()}, NO_FLAW, FRAME_BYTES);

		// random streams under low, high and random settings; last one runs flat out
		for (seg = 0; seg < SEGMENTS; seg++) begin
			case (seg)
				0: c = '0;
				1: c = '1;
				default: c = cfg_t'(40'({$urandom(), $urandom()}));
			endcase
			reconfigure(c);
			if (seg == 2)
				write_reg(REG_BEYOND, 8'($urandom_range(0, 255)));
			sender_idles = (seg != SEGMENTS - 1);
			receiver_stalls = (seg != SEGMENTS - 1);
			bytes_sent = 0;
			while (bytes_sent < SEGMENT_BYTES) begin
				pick = $urandom_range(0, 9);
				random_frame(fc, sfc, pl);
				if (pick < 7) begin
					send_frame(fc, sfc, pl, NO_FLAW, FRAME_BYTES);
				end else if (pick < 9) begin
					send_frame(fc, sfc, pl, $urandom_range(0, FRAME_BYTES - 1),
						$urandom_range(1, FRAME_BYTES));
				end else begin
					repeat ($urandom_range(1, 12)) send_byte(noise_byte());
				end
			end
		end

		drain_frames();
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[checksummed_frame_receiver_top.f]
hdl/cfr_pkg.sv
hdl/cfr_front.sv
hdl/cfr_fifo.sv
hdl/cfr_back.sv
hdl/checksummed_frame_receiver_top.sv
dv/cfr_frame_checker.sv
dv/tb_checksummed_frame_receiver_top.sv
